// File: hw/rtl/sme_pkg.sv
// Package: opcodes, status codes and sequencer states for the stack machine executor.
`default_nettype none
package sme_pkg;
  localparam int CmdBits    = 4;
  localparam int StatusBits = 3;
  localparam int ArgBits    = 32;
  localparam int OutBits    = 32;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0, OP_PUSH = 4'd1, OP_POP_REG = 4'd2, OP_PUSH_REG = 4'd3,
    OP_DUMP = 4'd4, OP_ADD = 4'd5, OP_SUB = 4'd6, OP_MUL = 4'd7,
    OP_DIV = 4'd8, OP_SQRT = 4'd9, OP_OUT = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_STACK = 3'd1, ST_DIV0 = 3'd2, ST_NEG_SQRT = 3'd3,
    ST_UNKNOWN = 3'd4, ST_HALTED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ_A, S_READ_B, S_ITER, S_FINISH, S_RESULT
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/sme_if.sv
// Interfaces: valid/ready channels for instructions and results.
`default_nettype none
interface sme_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [sme_pkg::CmdBits-1:0] cmd;
  logic signed [sme_pkg::ArgBits-1:0] arg;
  modport source (output valid, cmd, arg, input ready);
  modport sink   (input valid, cmd, arg, output ready);
endinterface

interface sme_res_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic signed [sme_pkg::OutBits-1:0] out_value;
  logic [sme_pkg::StatusBits-1:0] status;
  logic                          halted;
  modport source (output valid, out_valid, out_value, status, halted, input ready);
  modport sink   (input valid, out_valid, out_value, status, halted, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/stack_machine_executor.sv
// Top level: stack machine executor with an iterative shared arithmetic unit.
//
//  channel  | modport | transfer carries
//  ---------+---------+----------------------------------------------
//  in_ch    | sink    | cmd (4b), arg (32b signed)
//  res_ch   | source  | out_valid, out_value (32b), status (3b), halted
//
//  Halt, dump, unknown, halted and push go from the transfer in to S_RESULT;
//  stack reads add a read state per operand (memory has a registered read port).
//  Add, sub and mul finish in one pass of the shared unit; div iterates one
//  quotient bit per cycle for WORD_BITS quotient bits, sqrt one root bit per
//  cycle for WORD_BITS/2 root bits. Div sets the worst-case spacing between
//  transfers in.
//  Reset clears level, halt flag and register valid bits; the stack memory is
//  not cleared. The result register holds until taken; a new instruction is
//  taken in the same cycle the result transfers.
`default_nettype none
module stack_machine_executor #(
  parameter int STACK_DEPTH = 64,
  parameter int REG_COUNT   = 16,
  parameter int WORD_BITS   = 32
) (
  input wire logic clk,
  input wire logic rst,
  sme_cmd_if.sink  in_ch,
  sme_res_if.source res_ch
);
  import sme_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVW = $clog2(STACK_DEPTH + 1);
  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CW  = $clog2(WORD_BITS + 1);
  localparam int W   = WORD_BITS;

  // stack memory, one write and one registered read port
  logic [W-1:0] stack_mem [STACK_DEPTH];
  logic [W-1:0] rd_data;
  logic [SAW-1:0] rd_addr;
  logic         wr_en;
  logic [SAW-1:0] wr_addr;
  logic [W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    rd_data <= stack_mem[rd_addr];
  end

  // register file: flip-flops with valid bits, invalid reads as zero
  logic [W-1:0]         regs [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld;
  logic                 reg_we;
  logic [RAW-1:0]       reg_idx;
  logic [RAW-1:0]       reg_wr_idx;

  state_t state, state_next;
  logic [LVW-1:0] level, level_next;
  logic halt, halt_next;
  logic [CmdBits-1:0] op;
  logic [W-1:0] a, b, acc, rem, quo;
  logic [W-1:0] a_next, b_next, acc_next, rem_next, quo_next;
  logic [CW-1:0] cnt, cnt_next;
  logic sign_q, sign_next;
  logic r_valid, r_valid_next, r_ov, r_ov_next;
  logic [OutBits-1:0] r_val, r_val_next;
  logic [StatusBits-1:0] r_st, r_st_next;

  logic [W-1:0] imm, reg_rd, abs_a, sq_trial;
  logic [W:0]   div_trial;
  logic [W+1:0] sq_rem;
  logic         take;

  // register number is arg modulo REG_COUNT
  always_comb begin
    logic [ArgBits-1:0] au;
    au = ArgBits'(in_ch.arg);
    reg_idx = RAW'(au % ArgBits'(REG_COUNT));
  end

  assign imm    = W'({{64{in_ch.arg[ArgBits-1]}}, in_ch.arg});
  assign reg_rd = reg_vld[reg_idx] ? regs[reg_idx] : '0;

  // pop_reg writes later, so its register number is held from the transfer
  always_ff @(posedge clk) begin
    if (rst) reg_vld <= '0;
    else if (reg_we) reg_vld[reg_wr_idx] <= 1'b1;
    if (reg_we) regs[reg_wr_idx] <= rd_data;
  end

  assign abs_a = a[W-1] ? (W'(0) - a) : a;
  // restoring division step: rem holds partial remainder, quo shifts dividend bits out
  assign div_trial = {rem, quo[W-1]} - {1'b0, b};
  // sqrt step: acc is root, rem remainder, quo holds radicand bit pairs
  assign sq_rem   = {rem, quo[W-1:W-2]};
  assign sq_trial = {acc[W-3:0], 2'b01};

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && (!r_valid || res_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; level <= '0; halt <= 1'b0; r_valid <= 1'b0;
    end else begin
      state <= state_next; level <= level_next; halt <= halt_next;
      r_valid <= r_valid_next;
    end
    a <= a_next; b <= b_next; acc <= acc_next; rem <= rem_next; quo <= quo_next;
    cnt <= cnt_next; sign_q <= sign_next; r_ov <= r_ov_next; r_val <= r_val_next;
    r_st <= r_st_next;
    if (take) begin
      op <= in_ch.cmd;
      reg_wr_idx <= reg_idx;
    end
  end

  always_comb begin
    state_next = state; level_next = level; halt_next = halt;
    a_next = a; b_next = b; acc_next = acc; rem_next = rem; quo_next = quo;
    cnt_next = cnt; sign_next = sign_q;
    r_valid_next = r_valid && !res_ch.ready;
    r_ov_next = r_ov; r_val_next = r_val; r_st_next = r_st;
    wr_en = 1'b0; wr_addr = SAW'(level); wr_data = imm;
    rd_addr = SAW'(level - LVW'(1)); reg_we = 1'b0;
    case (state)
      S_IDLE: if (take) begin
        r_ov_next = 1'b0; r_val_next = '0; r_st_next = ST_OK;
        state_next = S_RESULT;
        if (halt) r_st_next = ST_HALTED;
        else case (in_ch.cmd)
          OP_HALT: halt_next = 1'b1;
          OP_PUSH, OP_PUSH_REG: begin
            if (level >= LVW'(STACK_DEPTH)) begin
              r_st_next = ST_STACK; halt_next = 1'b1;
            end else begin
              wr_en = 1'b1;
              wr_data = (in_ch.cmd == OP_PUSH) ? imm : reg_rd;
              level_next = level + LVW'(1);
            end
          end
          OP_DUMP: ;
          OP_POP_REG, OP_SQRT, OP_OUT: begin
            if (level < LVW'(1)) begin
              r_st_next = ST_STACK; halt_next = 1'b1;
            end else state_next = S_READ_A;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (level < LVW'(2)) begin
              r_st_next = ST_STACK; halt_next = 1'b1;
            end else state_next = S_READ_A;
          end
          default: r_st_next = ST_UNKNOWN;
        endcase
      end
      S_READ_A: begin
        // read of top issued last cycle; fetch next entry now
        rd_addr = SAW'(level - LVW'(2));
        a_next = rd_data;
        state_next = S_FINISH;
        case (op)
          OP_POP_REG: begin
            reg_we = 1'b1; level_next = level - LVW'(1);
          end
          OP_OUT: begin
            level_next = r_ov_next ? level : level - LVW'(1);
            r_ov_next = 1'b1;
            r_val_next = OutBits'({{64{rd_data[W-1]}}, rd_data});
          end
          OP_SQRT: begin
            if (rd_data[W-1]) r_st_next = ST_NEG_SQRT;
            else begin
              acc_next = '0; rem_next = '0; quo_next = rd_data;
              cnt_next = CW'(W / 2); state_next = S_ITER;
            end
          end
          default: state_next = S_READ_B;
        endcase
        if (op == OP_POP_REG || op == OP_OUT || (op == OP_SQRT && rd_data[W-1]))
          state_next = S_RESULT;
      end
      S_READ_B: begin
        b_next = rd_data;
        state_next = S_FINISH;
        if (op == OP_DIV) begin
          if (rd_data == '0) begin
            r_st_next = ST_DIV0; state_next = S_RESULT;
          end else begin
            rem_next = '0; quo_next = abs_a; cnt_next = CW'(W);
            state_next = S_ITER;
          end
        end
      end
      S_ITER: begin
        if (op == OP_DIV) begin
          if (!div_trial[W]) begin
            rem_next = div_trial[W-1:0];
            quo_next = {quo[W-2:0], 1'b1};
          end else begin
            rem_next = {rem[W-2:0], quo[W-1]};
            quo_next = {quo[W-2:0], 1'b0};
          end
          // b holds |b| for the whole loop, set on entry from S_READ_B
        end else begin
          if (sq_rem >= {2'b00, sq_trial}) begin
            rem_next = W'(sq_rem - {2'b00, sq_trial});
            acc_next = {acc[W-2:0], 1'b1};
          end else begin
            rem_next = W'(sq_rem);
            acc_next = {acc[W-2:0], 1'b0};
          end
          quo_next = {quo[W-3:0], 2'b00};
        end
        cnt_next = cnt - CW'(1);
        if (cnt == CW'(1)) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_RESULT;
        wr_en = 1'b1;
        case (op)
          OP_ADD: wr_data = a + b;
          OP_SUB: wr_data = a - b;
          OP_MUL: wr_data = W'(a * b);
          OP_DIV: wr_data = sign_q ? (W'(0) - quo) : quo;
          OP_SQRT: wr_data = acc;
          default: wr_en = 1'b0;
        endcase
        wr_addr = SAW'(level - LVW'((op == OP_SQRT) ? 1 : 2));
        if (op != OP_SQRT && wr_en) level_next = level - LVW'(1);
      end
      S_RESULT: begin
        r_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // division needs |b| and the quotient sign fixed at entry to the loop
    if (state == S_READ_B && op == OP_DIV) begin
      b_next = rd_data[W-1] ? (W'(0) - rd_data) : rd_data;
      sign_next = a[W-1] ^ rd_data[W-1];
    end
  end

  assign res_ch.valid     = r_valid;
  assign res_ch.out_valid = r_ov;
  assign res_ch.out_value = r_val;
  assign res_ch.status    = r_st;
  assign res_ch.halted    = halt;
endmodule
`default_nettype wire

// File: hw/rtl/sme_checker.sv
// Checker: port-level properties of the stack machine executor, bound to the top.
`default_nettype none
module sme_port_props (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic out_valid,
  input wire logic [2:0] status,
  input wire logic halted
);
  import sme_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halted) && res_valid |-> halted) else $error("halt cleared");
  a_out_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == ST_OK) else $error("out with error");
  a_stack_halts: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_STACK |-> halted) else $error("stack error not halted");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
endmodule

bind stack_machine_executor sme_port_props u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .res_valid(res_ch.valid), .res_ready(res_ch.ready), .out_valid(res_ch.out_valid),
  .status(res_ch.status), .halted(res_ch.halted)
);
`default_nettype wire

// File: verif/sme_checker.sv
// Checker for the stack machine executor: predicts each instruction's outcome and compares.
module sme_checker
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sme_cmd_if        in_ch,
  sme_res_if        res_ch,
  output int        fails,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam int Regs  = 16;

  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    status_t     status;
    logic        halted;
  } outcome_t;

  logic [31:0] stk [Depth];
  logic [31:0] regs [Regs];
  int          level;
  logic        stopped;
  outcome_t    outcomes [$];

  function automatic logic [31:0] isqrt(input logic [31:0] v);
    logic [31:0] res, b, rem;
    res = '0;
    b   = 32'h4000_0000;
    rem = v;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic predict(input logic [3:0] c, input logic [31:0] a);
    outcome_t    o;
    logic [31:0] x, y, q, mx, my;
    int          ri;
    o        = '0;
    o.status = ST_OK;
    ri       = int'(a[3:0]);
    if (stopped) begin
      o.status = ST_HALTED;
    end else begin
      case (op_t'(c))
        OP_HALT: stopped = 1'b1;
        OP_PUSH, OP_PUSH_REG: begin
          if (level >= Depth) o.status = ST_STACK;
          else begin
            stk[level] = (c == OP_PUSH) ? a : regs[ri];
            level++;
          end
        end
        OP_POP_REG: begin
          if (level < 1) o.status = ST_STACK;
          else begin
            level--;
            regs[ri] = stk[level];
          end
        end
        OP_DUMP: ;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (level < 2) o.status = ST_STACK;
          else begin
            x = stk[level-1];
            y = stk[level-2];
            if (c == OP_DIV && y == 0) o.status = ST_DIV0;
            else begin
              case (op_t'(c))
                OP_ADD:  q = x + y;
                OP_SUB:  q = x - y;
                OP_MUL:  q = x * y;
                default: begin
                  // magnitudes as unsigned, so most negative / -1 wraps back
                  mx = x[31] ? -x : x;
                  my = y[31] ? -y : y;
                  q  = mx / my;
                  if (x[31] ^ y[31]) q = -q;
                end
              endcase
              level = level - 1;
              stk[level-1] = q;
            end
          end
        end
        OP_SQRT: begin
          if (level < 1) o.status = ST_STACK;
          else if (stk[level-1][31]) o.status = ST_NEG_SQRT;
          else stk[level-1] = isqrt(stk[level-1]);
        end
        OP_OUT: begin
          if (level < 1) o.status = ST_STACK;
          else begin
            level--;
            o.emit  = 1'b1;
            o.value = stk[level];
          end
        end
        default: o.status = ST_UNKNOWN;
      endcase
      if (o.status == ST_STACK) stopped = 1'b1;
    end
    o.halted = stopped;
    outcomes.push_back(o);
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      level   = 0;
      stopped = 1'b0;
      fails   = 0;
      outcomes.delete();
      for (int i = 0; i < Regs; i++) regs[i] = '0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (outcomes.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          e = outcomes.pop_front();
          if (res_ch.out_valid !== e.emit || res_ch.out_value !== e.value ||
              res_ch.status !== e.status || res_ch.halted !== e.halted) begin
            fails++;
            if (fails <= 10)
              $display("result %0t: exp ov=%b val=%h st=%0d h=%b, got ov=%b val=%h st=%0d h=%b",
                       $realtime, e.emit, e.value, e.status, e.halted, res_ch.out_valid,
                       res_ch.out_value, res_ch.status, res_ch.halted);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict(in_ch.cmd, in_ch.arg);
    end
    pending = outcomes.size();
  end
endmodule

// File: verif/tb_top.sv
// Testbench top: instruction stimulus, result back-pressure and the final verdict.
module tb_top;
  import sme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   cyc;
  int   fails;
  int   pending;
  int   depth;   // exact stack depth, known because errors are held back to the end
  int   issued;

  sme_cmd_if in_ch ();
  sme_res_if res_ch ();

  stack_machine_executor DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .res_ch(res_ch));

  sme_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .res_ch(res_ch), .fails(fails), .pending(pending)
  );

  // Idle-free window shared by both sides
  wire calm = (cyc >= 8000) && (cyc < 14000);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout; generous over the slowest correct run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= 600000) begin
      $display("stack_machine_executor: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up
  // and stalls its input while the sender keeps offering.
  int hold;
  always @(posedge clk) begin
    if (rst) begin
      hold <= 0;
      res_ch.ready <= 1'b0;
    end else if (cyc == 3000) begin
      hold <= 400;
      res_ch.ready <= 1'b0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // One instruction transfer, with random idle cycles before it.
  // valid stays high between back-to-back items.
  task automatic send(input logic [3:0] c, input logic [31:0] a, input int d);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.arg   <= a;
    do @(posedge clk); while (!in_ch.ready);
    depth  += d;
    issued++;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(20);
      3:       return -$urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int r;
    logic [31:0] b;
    cyc          = 0;
    depth        = 0;
    issued       = 0;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = '0;
    in_ch.arg    = '0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: add of the extremes, divide overflow, divide by zero, negative root,
    // largest root, register index wrap, reset-cleared register, every opcode but halt.
    send(OP_PUSH, 32'h7FFF_FFFF, 1);
    send(OP_PUSH, 32'h8000_0000, 1);
    send(OP_ADD, 0, -1);
    send(OP_OUT, 0, -1);
    send(OP_PUSH, 32'hFFFF_FFFF, 1);
    send(OP_PUSH, 32'h8000_0000, 1);
    send(OP_DIV, 0, -1);
    send(OP_OUT, 0, -1);
    send(OP_PUSH, 0, 1);
    send(OP_PUSH, 7, 1);
    send(OP_DIV, 0, 0);                  // divisor zero: both operands remain
    send(OP_SUB, 0, -1);
    send(OP_PUSH, -4, 1);
    send(OP_SQRT, 0, 0);                 // negative root: operand remains
    send(OP_MUL, 0, -1);
    send(OP_PUSH, 32'h7FFF_FFFF, 1);
    send(OP_SQRT, 0, 0);
    send(OP_POP_REG, 32'hFFFF_FFFF, -1); // register 15
    send(OP_PUSH_REG, 15, 1);
    send(OP_PUSH_REG, 3, 1);             // still zero from reset
    send(OP_OUT, 0, -1);
    send(OP_OUT, 0, -1);
    send(OP_OUT, 0, -1);
    send(OP_DUMP, 0, 0);
    send(4'd11, 0, 0);
    send(4'd15, 32'hFFFF_FFFF, 0);

    // Random programmes: mostly legal sequences, occasional noise opcodes
    while (issued < 1030) begin
      r = $urandom_range(99);
      if ((depth < 2 || r < 30) && depth < 61) begin
        if ($urandom_range(3) == 0) send(OP_PUSH_REG, $urandom, 1);
        else send(OP_PUSH, rnd_word(), 1);
      end else if (depth >= 61) begin
        send($urandom_range(1) ? OP_OUT : OP_POP_REG, $urandom, -1);
      end else if (r < 45) begin
        send(4'(OP_ADD + $urandom_range(2)), $urandom, -1);
      end else if (r < 55) begin
        // divisor is pushed first so its zeroness is known
        b = ($urandom_range(7) == 0) ? 32'd0 : rnd_word();
        send(OP_PUSH, b, 1);
        send(OP_PUSH, rnd_word(), 1);
        send(OP_DIV, $urandom, (b == 0) ? 0 : -1);
      end else if (r < 65) begin
        send(OP_SQRT, $urandom, 0);
      end else if (r < 80) begin
        send(OP_OUT, $urandom, -1);
      end else if (r < 90) begin
        send(OP_POP_REG, $urandom, -1);
      end else if (r < 95) begin
        send(OP_PUSH_REG, $urandom, 1);
      end else if (r < 97) begin
        send(OP_DUMP, $urandom, 0);
      end else begin
        send(4'($urandom_range(15, 11)), $urandom, 0);
      end
    end

    // Ending: one way of stopping the machine, then instructions it ignores
    case ($urandom_range(2))
      0: send(OP_HALT, $urandom, 0);
      1: begin
        while (depth > 0) send(OP_OUT, 0, -1);
        send(OP_POP_REG, 5, 0);          // underflow
      end
      default: begin
        while (depth < 64) send(OP_PUSH, $urandom, 1);
        send(OP_PUSH, 1, 0);             // overflow
      end
    endcase
    send(OP_PUSH, 9, 0);
    send(OP_ADD, 0, 0);
    send(OP_HALT, 0, 0);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("stack_machine_executor: match");
    end else begin
      $display("stack_machine_executor: mismatch");
    end
    $finish;
  end
endmodule
